// File: rtl/core/gsx_pkg.sv
// Shared types, register codes and helpers for the RGB to RGBW gamut stretch block.
// Used by the top level, gsx_front and gsx_back; depends on nothing.
package gsx_pkg;

	localparam int EQ_W  = 16;
	localparam int CFG_AW = 3;

	typedef enum logic [CFG_AW-1:0] {
		REG_RED_EQUIV   = 3'd0,
		REG_GREEN_EQUIV = 3'd1,
		REG_BLUE_EQUIV  = 3'd2,
		REG_WHITE_EQUIV = 3'd3,
		REG_OVERDRIVE   = 3'd4
	} cfg_reg_t;

	localparam logic [EQ_W-1:0] RED_EQUIV_RST   = 16'd10000;
	localparam logic [EQ_W-1:0] GREEN_EQUIV_RST = 16'd6400;
	localparam logic [EQ_W-1:0] BLUE_EQUIV_RST  = 16'd3568;
	localparam logic [EQ_W-1:0] WHITE_EQUIV_RST = 16'd10000;
	localparam logic [EQ_W-1:0] OVERDRIVE_RST   = 16'd9830;

	// An equivalence of zero is taken as the smallest nonzero step.
	function automatic logic [EQ_W-1:0] nz(input logic [EQ_W-1:0] v);
		return (v == '0) ? EQ_W'(1) : v;
	endfunction

endpackage

// File: rtl/core/rgb_to_rgbw_gamut_stretch.sv
// Channel      | Direction | Contents
// s_t*         | in        | one RGB pixel per beat
// m_t*         | out       | one RGBW pixel per beat
// cfg_*        | in        | register writes, no read-back
//
// One pixel is accepted every cycle while the output is not stalled. The pipeline is long
// mainly because of the two chains of one-bit divider stages (QB = 22 is the stretch width at CB = 8):
// the saturation quotient and the final scaling by white_equiv. The pipeline advances as a
// whole whenever the output beat is empty or taken, so s_tready follows m_tready within
// the cycle.
// Reset clears the valid bits and loads the register defaults.
module rgb_to_rgbw_gamut_stretch #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// red_in, green_in, blue_in from the lowest bit up, zero padded
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// red_out, green_out, blue_out, white_out from the lowest bit up, zero padded
	output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
	input  logic                               cfg_we,
	input  logic [gsx_pkg::CFG_AW-1:0]         cfg_addr,
	input  logic [gsx_pkg::EQ_W-1:0]           cfg_wdata
);

	localparam int CB    = CHANNEL_BITS;
	localparam int OW    = ((4*CB+7)/8)*8;
	localparam longint CMAX  = (64'd1 << CB) - 1;
	localparam longint S1MAX = (CMAX * 262144 + 64'd32767 * 65535) / (4 * CMAX);
	localparam int QB    = $clog2(S1MAX + 1);
	localparam int LD    = QB + 1;
	localparam int LAT   = 1 + LD + 4 + CB + 1;
	localparam int AW    = (CB + 20 > 34) ? CB + 20 : 34;
	localparam int PYW   = 4 * CB;
	localparam logic [AW-1:0] BASE = AW'(CMAX * 262144);
	localparam int NY    = AW - 3;
	localparam int SH    = NY + CB;
	localparam longint RCP = ((64'd1 << SH) + CMAX - 1) / CMAX;
	localparam logic [NY:0] RCP_K = (NY+1)'(RCP);

	logic [gsx_pkg::EQ_W-1:0] er_q, eg_q, eb_q, ew_q, ovd_q;
	logic [gsx_pkg::EQ_W-1:0] er, eg, eb, ew;

	logic                 adv;
	logic [LAT-1:0]       vld_q;
	logic [PYW-1:0]       pay_q [LD];

	logic signed [32:0]   ovw;
	logic signed [AW-1:0] an;
	logic [AW-2:0]        n1_q;
	logic [2*NY:0]        s1p_q;
	logic [QB-1:0]        s1_quo, s2_quo;

	logic [32+CB-1:0]     n_s1;
	logic [16+CB-1:0]     d_s1;
	logic [CB-1:0]        r_s1, g_s1, b_s1, lo_s1;
	logic [CB-1:0]        red_out, green_out, blue_out, white_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			er_q  <= gsx_pkg::RED_EQUIV_RST;
			eg_q  <= gsx_pkg::GREEN_EQUIV_RST;
			eb_q  <= gsx_pkg::BLUE_EQUIV_RST;
			ew_q  <= gsx_pkg::WHITE_EQUIV_RST;
			ovd_q <= gsx_pkg::OVERDRIVE_RST;
		end else if (cfg_we) begin
			unique case (gsx_pkg::cfg_reg_t'(cfg_addr))
				gsx_pkg::REG_RED_EQUIV:   er_q  <= cfg_wdata;
				gsx_pkg::REG_GREEN_EQUIV: eg_q  <= cfg_wdata;
				gsx_pkg::REG_BLUE_EQUIV:  eb_q  <= cfg_wdata;
				gsx_pkg::REG_WHITE_EQUIV: ew_q  <= cfg_wdata;
				gsx_pkg::REG_OVERDRIVE:   ovd_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign er = gsx_pkg::nz(er_q);
	assign eg = gsx_pkg::nz(eg_q);
	assign eb = gsx_pkg::nz(eb_q);
	assign ew = gsx_pkg::nz(ew_q);

	assign adv      = !vld_q[LAT-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// The overdrive limit depends only on the registers. It runs every cycle and settles
	// through the n1_q and s1p_q registers after a write, long before a pixel accepted after that write reaches
	// the minimum stage. The division by 4*CMAX drops the factor four as a shift and
	// divides by CMAX with an exact reciprocal multiplication.
	assign ovw = $signed(ovd_q) * $signed({1'b0, ew});
	assign an  = $signed(BASE) + AW'(ovw);

	always_ff @(posedge clk) begin
		n1_q  <= an[AW-1] ? '0 : an[AW-2:0];
		s1p_q <= (2*NY+1)'(n1_q[AW-2:2]) * (2*NY+1)'(RCP_K);
	end

	assign s1_quo = QB'(s1p_q >> SH);

	gsx_front #(.CB(CB)) u_front (
		.clk(clk), .en(adv),
		.r(s_tdata[CB-1:0]), .g(s_tdata[2*CB-1:CB]), .b(s_tdata[3*CB-1:2*CB]),
		.er(er), .eg(eg), .eb(eb), .w(ew),
		.n_s1(n_s1), .d_s1(d_s1),
		.r_s1(r_s1), .g_s1(g_s1), .b_s1(b_s1), .lo_s1(lo_s1)
	);

	gsx_div #(.NW(32+CB), .DW(16+CB), .QW(QB)) u_div_s2 (
		.clk(clk), .en(adv), .num(n_s1), .den(d_s1), .quo(s2_quo)
	);

	// Pixel channels ride alongside the quotient chain.
	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q[0] <= {lo_s1, b_s1, g_s1, r_s1};
			for (int k = 1; k < LD; k++) begin
				pay_q[k] <= pay_q[k-1];
			end
		end
	end

	gsx_back #(.CB(CB), .QB(QB)) u_back (
		.clk(clk), .en(adv),
		.s1(s1_quo), .s2(s2_quo),
		.r(pay_q[LD-1][CB-1:0]), .g(pay_q[LD-1][2*CB-1:CB]),
		.b(pay_q[LD-1][3*CB-1:2*CB]), .lo(pay_q[LD-1][4*CB-1:3*CB]),
		.er(er), .eg(eg), .eb(eb), .w(ew),
		.red_out(red_out), .green_out(green_out),
		.blue_out(blue_out), .white_out(white_out)
	);

	assign m_tdata = OW'({white_out, blue_out, green_out, red_out});

endmodule

// File: rtl/core/gsx_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating on overflow.
// Uses no package items; instantiated by gsx_back and the top level.
module gsx_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int QW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic          ovf_s [QW+1];

	// A quotient that does not fit in QW bits is flagged up front and forced to all ones.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(num);
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= RW'(num) >= (RW'(den) << QW);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int BIT = QW - 1 - k;
		logic [RW-1:0] shd;
		logic          ge;
		assign shd = RW'(den_s[k]) << BIT;
		assign ge  = rem_s[k] >= shd;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - shd : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= quo_s[k] | (QW'(ge) << BIT);
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quo = ovf_s[QW] ? '1 : quo_s[QW];

endmodule

// File: rtl/core/gsx_front.sv
// Input stage: picks the brightest and darkest channel and forms the saturation quotient terms.
// Depends on gsx_pkg.
module gsx_front #(
	parameter int CB = 8
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [CB-1:0]             r,
	input  logic [CB-1:0]             g,
	input  logic [CB-1:0]             b,
	input  logic [gsx_pkg::EQ_W-1:0]  er,
	input  logic [gsx_pkg::EQ_W-1:0]  eg,
	input  logic [gsx_pkg::EQ_W-1:0]  eb,
	input  logic [gsx_pkg::EQ_W-1:0]  w,
	output logic [32+CB-1:0]          n_s1,
	output logic [16+CB-1:0]          d_s1,
	output logic [CB-1:0]             r_s1,
	output logic [CB-1:0]             g_s1,
	output logic [CB-1:0]             b_s1,
	output logic [CB-1:0]             lo_s1
);

	logic [CB-1:0]            hi_a, hi, lo_a, lo;
	logic [gsx_pkg::EQ_W-1:0] eh_a, eh;

	// Red wins over green on a tie; blue wins only when strictly brighter.
	always_comb begin
		if (g > r) begin
			hi_a = g;
			eh_a = eg;
		end else begin
			hi_a = r;
			eh_a = er;
		end
		if (b > hi_a) begin
			hi = b;
			eh = eb;
		end else begin
			hi = hi_a;
			eh = eh_a;
		end
		lo_a = (r < g) ? r : g;
		lo   = (b < lo_a) ? b : lo_a;
	end

	// A flat pixel gives a zero divisor, which the divider saturates.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= (32+CB)'(w) * (32+CB)'(hi) << 16;
			d_s1  <= (16+CB)'(eh) * (16+CB)'(hi - lo);
			r_s1  <= r;
			g_s1  <= g;
			b_s1  <= b;
			lo_s1 <= lo;
		end
	end

endmodule

// File: rtl/core/gsx_back.sv
// Output half: applies the stretch, splits off white and scales each drive by white_equiv.
// Depends on gsx_pkg and gsx_div.
module gsx_back #(
	parameter int CB = 8,
	parameter int QB = 21
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [QB-1:0]             s1,
	input  logic [QB-1:0]             s2,
	input  logic [CB-1:0]             r,
	input  logic [CB-1:0]             g,
	input  logic [CB-1:0]             b,
	input  logic [CB-1:0]             lo,
	input  logic [gsx_pkg::EQ_W-1:0]  er,
	input  logic [gsx_pkg::EQ_W-1:0]  eg,
	input  logic [gsx_pkg::EQ_W-1:0]  eb,
	input  logic [gsx_pkg::EQ_W-1:0]  w,
	output logic [CB-1:0]             red_out,
	output logic [CB-1:0]             green_out,
	output logic [CB-1:0]             blue_out,
	output logic [CB-1:0]             white_out
);

	localparam int PW   = QB + CB;
	localparam int FW   = (PW > 28) ? PW : 28;
	localparam int MW   = PW + 18;
	localparam int NO   = PW + CB + 2;
	localparam int CMAX = (1 << CB) - 1;

	logic [QB-1:0] st_s1;
	logic [CB-1:0] r_s1, g_s1, b_s1, lo_s1;
	logic [PW-1:0] pr_s2, pg_s2, pb_s2, pl_s2;
	logic [PW-1:0] dr_s3, dg_s3, db_s3, fl_s3;
	logic [NO-1:0] nr_s4, ng_s4, nb_s4, nw_s4;

	logic [FW-1:0] plx, wqx;
	logic [PW-1:0] fl;
	logic [MW-1:0] mr, mg, mb;
	logic [NO-1:0] mw;

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= (s1 < s2) ? s1 : s2;
			r_s1  <= r;
			g_s1  <= g;
			b_s1  <= b;
			lo_s1 <= lo;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2 <= PW'(st_s1) * PW'(r_s1);
			pg_s2 <= PW'(st_s1) * PW'(g_s1);
			pb_s2 <= PW'(st_s1) * PW'(b_s1);
			pl_s2 <= PW'(st_s1) * PW'(lo_s1);
		end
	end

	// White takes the stretched minimum, but never more than white_equiv.
	assign plx = FW'(pl_s2);
	assign wqx = FW'(w) << 12;
	assign fl  = (plx < wqx) ? pl_s2 : PW'(wqx);

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s3 <= pr_s2 - fl;
			dg_s3 <= pg_s2 - fl;
			db_s3 <= pb_s2 - fl;
			fl_s3 <= fl;
		end
	end

	// The half-up rounding term is added here; the low bits of the divisor are
	// stripped off the numerator so the dividers only see white_equiv.
	assign mr = ((MW'(dr_s3) * MW'(er)) << 1) + (MW'(w) << 16);
	assign mg = ((MW'(dg_s3) * MW'(eg)) << 1) + (MW'(w) << 16);
	assign mb = ((MW'(db_s3) * MW'(eb)) << 1) + (MW'(w) << 16);
	assign mw = ((NO'(fl_s3) * NO'(CMAX)) << 1) + (NO'(w) << 12);

	always_ff @(posedge clk) begin
		if (en) begin
			nr_s4 <= NO'(mr >> 17);
			ng_s4 <= NO'(mg >> 17);
			nb_s4 <= NO'(mb >> 17);
			nw_s4 <= mw >> 13;
		end
	end

	// A quotient of all ones is exactly the channel maximum, so overflow saturates.
	gsx_div #(.NW(NO), .DW(gsx_pkg::EQ_W), .QW(CB)) u_div_r (
		.clk(clk), .en(en), .num(nr_s4), .den(w), .quo(red_out)
	);
	gsx_div #(.NW(NO), .DW(gsx_pkg::EQ_W), .QW(CB)) u_div_g (
		.clk(clk), .en(en), .num(ng_s4), .den(w), .quo(green_out)
	);
	gsx_div #(.NW(NO), .DW(gsx_pkg::EQ_W), .QW(CB)) u_div_b (
		.clk(clk), .en(en), .num(nb_s4), .den(w), .quo(blue_out)
	);
	gsx_div #(.NW(NO), .DW(gsx_pkg::EQ_W), .QW(CB)) u_div_w (
		.clk(clk), .en(en), .num(nw_s4), .den(w), .quo(white_out)
	);

endmodule

// File: rtl/core/gsx_chk.sv
// Port-level checks for the gamut stretch block, bound to its top level.
// Depends only on the top level's ports.
module gsx_chk #(
	parameter int DW = 32
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [DW-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("output beat dropped without being taken");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output side");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready))
		else $error("output beat appeared while the pipeline was stalled");

endmodule

bind rgb_to_rgbw_gamut_stretch gsx_chk #(.DW($bits(m_tdata))) u_gsx_chk (.*);
